### rtl/lkp_pkg.sv
// lkp_pkg: beat types, field widths and code constants for the k-permutation generator
// used by lex_k_permutation_generator_unit and its testbench; no dependencies
package lkp_pkg;

  localparam int VAL_W   = 16;  // value field on both channels
  localparam int FUNC_W  = 2;
  localparam int LEN_W   = 4;   // perm_length register
  localparam int POS_W   = 3;
  localparam int ST_W    = 2;
  localparam int MAX_LEN = 8;   // deepest permutation, levels of the index stack

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd2;

  localparam logic [ST_W-1:0] ST_ELEM    = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUST = 2'd1;
  localparam logic [ST_W-1:0] ST_DROP    = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VAL_W-1:0]  value;
  } in_beat_t;

  typedef struct packed {
    logic [VAL_W-1:0] out_value;
    logic [POS_W-1:0] position;
    logic             last;
    logic [ST_W-1:0]  status;
  } out_beat_t;

endpackage

### rtl/lkp_free_find.sv
// lkp_free_find: lowest store index in [from, count) whose used bit is clear
// shared search unit of the permutation sequencer; no package dependencies
module lkp_free_find #(
  parameter int MAX_ITEMS = 8,
  parameter int IW        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
  input  logic [MAX_ITEMS-1:0] used,
  input  logic [CW-1:0]        from,
  input  logic [CW-1:0]        count,
  output logic                 found,
  output logic [IW-1:0]        idx
);

  logic [MAX_ITEMS-1:0] cand;
  logic [MAX_ITEMS-1:0] low;

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      cand[i] = !used[i] && (CW'(i) >= from) && (CW'(i) < count);
    end
    // isolate the lowest candidate, then encode it
    low = cand & (~cand + MAX_ITEMS'(1));
    idx = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (low[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

  assign found = |cand;

endmodule

### rtl/lex_k_permutation_generator_unit.sv
// lex_k_permutation_generator_unit: sorted value store and lexicographic k-permutation walk
// depends on lkp_pkg and lkp_free_find
//
//   port group   dir  handshake            beat
//   in_*         in   in_valid / in_stall   lkp_pkg::in_beat_t (func, value)
//   out_*        out  out_valid / out_stall lkp_pkg::out_beat_t (out_value, position, last, status)
//   cfg_*        in   cfg_wr_en             perm_length
//
// one input beat at a time; in_stall is high while the sequencer is not idle (clear and unused codes leave it idle)
// clear: done in the idle state as the beat is accepted
// load: reads and compares store entries one at a time (one store read port), shifting larger ones up
// next: unwinds or refills the stack levels one by one through the shared free-index search,
//   closes the refill, then reads each element from the store and loads it into the output
// drop and exhausted results, repeated or from a failed advance, are one status beat
// output stalls hold the sequencer; rst_n is synchronous; store and index stack not reset
module lex_k_permutation_generator_unit #(
  parameter int MAX_ITEMS  = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lkp_pkg::in_beat_t           in_beat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lkp_pkg::out_beat_t          out_beat,
  input  logic                        cfg_wr_en,
  input  logic [lkp_pkg::LEN_W-1:0]   cfg_wr_data
);

  localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int SW    = (VALUE_BITS < lkp_pkg::VAL_W) ? VALUE_BITS : lkp_pkg::VAL_W;
  localparam int LW    = lkp_pkg::LEN_W;
  localparam int PW    = lkp_pkg::POS_W;
  localparam int OW    = lkp_pkg::VAL_W;
  localparam int DW    = $clog2(lkp_pkg::MAX_LEN);
  localparam int XW    = (LW > CW) ? LW : CW;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_RD  = 8'b0000_0010,
    S_INS_CMP = 8'b0000_0100,
    S_FILL    = 8'b0000_1000,
    S_ADV     = 8'b0001_0000,
    S_EM_RD   = 8'b0010_0000,
    S_EM_OUT  = 8'b0100_0000,
    S_ONE     = 8'b1000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [LW-1:0]            len_r, len_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [MAX_ITEMS-1:0]     used_r, used_nxt;
  logic                     started_r, started_nxt;
  logic                     finished_r, finished_nxt;
  logic [LW-1:0]            lvl_r, lvl_nxt;
  logic [CW-1:0]            p_r, p_nxt;
  logic [SW-1:0]            val_r, val_nxt;
  logic [lkp_pkg::ST_W-1:0] code_r, code_nxt;
  logic                     out_valid_r;
  lkp_pkg::out_beat_t       out_beat_r, out_beat_nxt;

  logic [SW-1:0]            mem [MAX_ITEMS];
  logic [SW-1:0]            rd_data_r;
  logic [IW-1:0]            chosen_r [lkp_pkg::MAX_LEN];

  logic                     mem_we;
  logic [IW-1:0]            mem_wa;
  logic [SW-1:0]            mem_wd;
  logic [IW-1:0]            rd_addr;
  logic                     ch_we;
  logic [DW-1:0]            ch_addr;
  logic [IW-1:0]            cur_ch;
  logic [MAX_ITEMS-1:0]     cleared;
  logic [MAX_ITEMS-1:0]     ff_used;
  logic [CW-1:0]            ff_from;
  logic                     ff_found;
  logic [IW-1:0]            ff_idx;
  logic                     out_free;
  logic                     out_ld;
  logic                     len_bad;
  logic                     em_last;

  // index stack read: unwinding looks one level below the pointer
  assign ch_addr = (state_r == S_ADV) ? DW'(lvl_r - LW'(1)) : DW'(lvl_r);
  assign cur_ch  = chosen_r[ch_addr];
  assign cleared = used_r & ~(MAX_ITEMS'(1) << cur_ch);
  assign ff_used = (state_r == S_ADV) ? cleared : used_r;
  assign ff_from = (state_r == S_ADV) ? (CW'(cur_ch) + CW'(1)) : '0;

  lkp_free_find #(
    .MAX_ITEMS (MAX_ITEMS),
    .IW        (IW),
    .CW        (CW)
  ) u_find (
    .used  (ff_used),
    .from  (ff_from),
    .count (cnt_r),
    .found (ff_found),
    .idx   (ff_idx)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign len_bad  = (len_r == '0) || (len_r > LW'(lkp_pkg::MAX_LEN)) ||
                    (XW'(len_r) > XW'(cnt_r));
  assign em_last  = (lvl_r == len_r - LW'(1));

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    used_nxt     = used_r;
    started_nxt  = started_r;
    finished_nxt = finished_r;
    lvl_nxt      = lvl_r;
    p_nxt        = p_r;
    val_nxt      = val_r;
    code_nxt     = code_r;
    mem_we       = 1'b0;
    mem_wa       = p_r[IW-1:0];
    mem_wd       = val_r;
    rd_addr      = cur_ch;
    ch_we        = 1'b0;
    out_ld       = 1'b0;
    out_beat_nxt = out_beat_r;

    if (cfg_wr_en) begin
      len_nxt      = cfg_wr_data;
      used_nxt     = '0;
      started_nxt  = 1'b0;
      finished_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_beat.func)
            lkp_pkg::FUNC_CLEAR: begin
              cnt_nxt      = '0;
              used_nxt     = '0;
              started_nxt  = 1'b0;
              finished_nxt = 1'b0;
            end
            lkp_pkg::FUNC_LOAD: begin
              val_nxt = in_beat.value[SW-1:0];
              p_nxt   = cnt_r;
              if (cnt_r >= CW'(MAX_ITEMS)) begin
                code_nxt  = lkp_pkg::ST_DROP;
                state_nxt = S_ONE;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            lkp_pkg::FUNC_NEXT: begin
              if (finished_r) begin
                code_nxt  = lkp_pkg::ST_EXHAUST;
                state_nxt = S_ONE;
              end else if (!started_r) begin
                if (len_bad) begin
                  finished_nxt = 1'b1;
                  code_nxt     = lkp_pkg::ST_EXHAUST;
                  state_nxt    = S_ONE;
                end else begin
                  used_nxt  = '0;
                  lvl_nxt   = '0;
                  state_nxt = S_FILL;
                end
              end else begin
                lvl_nxt   = len_r;
                state_nxt = S_ADV;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        if (p_r == '0) begin
          mem_we       = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
          used_nxt     = '0;
          started_nxt  = 1'b0;
          finished_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          rd_addr   = IW'(p_r - CW'(1));
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_data_r > val_r) begin
          // shift the larger neighbor up one slot
          mem_wd    = rd_data_r;
          p_nxt     = p_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt      = cnt_r + CW'(1);
          used_nxt     = '0;
          started_nxt  = 1'b0;
          finished_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      S_FILL: begin
        if (lvl_r == len_r) begin
          started_nxt = 1'b1;
          lvl_nxt     = '0;
          state_nxt   = S_EM_RD;
        end else begin
          ch_we    = 1'b1;
          used_nxt = used_r | (MAX_ITEMS'(1) << ff_idx);
          lvl_nxt  = lvl_r + LW'(1);
        end
      end
      S_ADV: begin
        if (lvl_r == '0) begin
          finished_nxt = 1'b1;
          code_nxt     = lkp_pkg::ST_EXHAUST;
          state_nxt    = S_ONE;
        end else if (ff_found) begin
          // bump this level, refill the levels above it
          ch_we     = 1'b1;
          used_nxt  = cleared | (MAX_ITEMS'(1) << ff_idx);
          state_nxt = S_FILL;
        end else begin
          used_nxt = cleared;
          lvl_nxt  = lvl_r - LW'(1);
        end
      end
      S_EM_RD: begin
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_ld                 = 1'b1;
          out_beat_nxt.out_value = OW'(rd_data_r);
          out_beat_nxt.position  = PW'(lvl_r);
          out_beat_nxt.last      = em_last;
          out_beat_nxt.status    = lkp_pkg::ST_ELEM;
          if (em_last) begin
            state_nxt = S_IDLE;
          end else begin
            lvl_nxt   = lvl_r + LW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_ld                 = 1'b1;
          out_beat_nxt.out_value = '0;
          out_beat_nxt.position  = '0;
          out_beat_nxt.last      = 1'b1;
          out_beat_nxt.status    = code_r;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LW'(1);
      cnt_r       <= '0;
      used_r      <= '0;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      used_r     <= used_nxt;
      started_r  <= started_nxt;
      finished_r <= finished_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    p_r        <= p_nxt;
    val_r      <= val_nxt;
    code_r     <= code_nxt;
    out_beat_r <= out_beat_nxt;
    if (ch_we) begin
      chosen_r[ch_addr] <= ff_idx;
    end
  end

  // sorted value store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status == lkp_pkg::ST_ELEM && out_beat.last
      |-> out_beat.position == PW'(len_r - LW'(1)))
    else $error("last element beat not at final position");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status != lkp_pkg::ST_ELEM
      |-> out_beat.last && out_beat.position == '0)
    else $error("status beat not a single last beat");

  a_used_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EM_RD |-> $countones(used_r) == int'(len_r))
    else $error("used mask does not match permutation length");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS))
    else $error("item count above store depth");

endmodule

### sim/tb_lex_k_permutation_generator_unit.sv
// tb_lex_k_permutation_generator_unit: self-checking bench for the sorted store and walk
// sends clear, load and next beats under perm_length settings and checks every result beat
// depends on lkp_pkg and lex_k_permutation_generator_unit
module tb_lex_k_permutation_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FUNC_W  = lkp_pkg::FUNC_W;
  localparam int VAL_W   = lkp_pkg::VAL_W;
  localparam int LEN_W   = lkp_pkg::LEN_W;
  localparam int POS_W   = lkp_pkg::POS_W;
  localparam int MAX_LEN = lkp_pkg::MAX_LEN;

  localparam int DEPTH = 8;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;  // unused code, block ignores it
  localparam int IDLE_GAP = 40;
  localparam int QUIET_LIMIT = 3000;
  localparam int RAND_ITEMS = 200;
  localparam int MAX_REPORTS = 100;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HALF, STALL_TEETH} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lkp_pkg::in_beat_t  in_beat = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lkp_pkg::out_beat_t out_beat;
  logic               cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]   cfg_wr_data = '0;

  // predicted block state
  logic [VAL_W-1:0] store_vals [DEPTH];
  int               store_cnt;
  int               pick_idx [MAX_LEN];
  logic [DEPTH-1:0] taken;
  bit               walk_started;
  bit               walk_done;
  logic [LEN_W-1:0] perm_len;

  lkp_pkg::out_beat_t perm_q [$];
  int                 mismatches = 0;
  int                 burst_left = 0;
  int                 quiet_cycles = 0;
  int                 stall_run = 0;
  stall_mode_t        stall_mode = STALL_NONE;

  lex_k_permutation_generator_unit #(
    .MAX_ITEMS(DEPTH),
    .VALUE_BITS(VAL_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void restart_walk();
    taken = '0;
    walk_started = 1'b0;
    walk_done = 1'b0;
    foreach (pick_idx[i]) pick_idx[i] = 0;
  endfunction

  // queue one expected result beat at the tail
  function automatic void expect_beat(lkp_pkg::out_beat_t r);
    perm_q = {perm_q, r};
  endfunction

  // lowest store index at or above from that no level holds, store_cnt if none
  function automatic int lowest_free(int from);
    for (int j = from; j < store_cnt; j++)
      if (!taken[j]) return j;
    return store_cnt;
  endfunction

  function automatic void fill_levels(int d, int len);
    int j;
    for (int k = d; k < len; k++) begin
      j = lowest_free(0);
      pick_idx[k] = j;
      taken[j] = 1'b1;
    end
  endfunction

  // unwind the index stack from the deepest level until one can move up
  function automatic bit next_pick(int len);
    int j;
    for (int d = len - 1; d >= 0; d--) begin
      taken[pick_idx[d]] = 1'b0;
      j = lowest_free(pick_idx[d] + 1);
      if (j < store_cnt) begin
        pick_idx[d] = j;
        taken[j] = 1'b1;
        fill_levels(d + 1, len);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_beat(lkp_pkg::in_beat_t b);
    int                 len;
    int                 p;
    lkp_pkg::out_beat_t r;
    len = int'(perm_len);
    r = '0;
    case (b.func)
      lkp_pkg::FUNC_CLEAR: begin
        store_cnt = 0;
        restart_walk();
      end
      lkp_pkg::FUNC_LOAD: begin
        if (store_cnt >= DEPTH) begin
          r.last = 1'b1;
          r.status = lkp_pkg::ST_DROP;
          expect_beat(r);
        end else begin
          p = store_cnt;
          while (p > 0 && store_vals[p-1] > b.value) begin
            store_vals[p] = store_vals[p-1];
            p--;
          end
          store_vals[p] = b.value;
          store_cnt++;
          restart_walk();
        end
      end
      lkp_pkg::FUNC_NEXT: begin
        if (!walk_done) begin
          if (!walk_started) begin
            if (len == 0 || len > MAX_LEN || len > store_cnt) begin
              walk_done = 1'b1;
            end else begin
              taken = '0;
              fill_levels(0, len);
              walk_started = 1'b1;
            end
          end else if (!next_pick(len)) begin
            walk_done = 1'b1;
          end
        end
        if (walk_done) begin
          r.last = 1'b1;
          r.status = lkp_pkg::ST_EXHAUST;
          expect_beat(r);
        end else begin
          for (int i = 0; i < len; i++) begin
            r.out_value = store_vals[pick_idx[i]];
            r.position = POS_W'(i);
            r.last = (i == len - 1);
            r.status = lkp_pkg::ST_ELEM;
            expect_beat(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return VAL_W'($urandom_range(0, 3));  // repeats likely
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // one input beat; valid stays up across a burst
  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_beat <= '{func: f, value: v};
    do @(posedge clk); while (in_stall);
    predict_beat(in_beat);
  endtask

  // drain: nothing in flight and the sequencer idle, plus room for result-free work
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (perm_q.size() != 0 || in_stall) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    perm_len = len;
    restart_walk();
  endtask

  task automatic test_default_length();
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);   // empty store
    send_beat(lkp_pkg::FUNC_LOAD, 16'hFFFF);
    send_beat(lkp_pkg::FUNC_LOAD, 16'h0000);
    send_beat(lkp_pkg::FUNC_NEXT, 16'hFFFF);
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);   // walk over
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);   // stays over
  endtask

  task automatic test_store_full();
    send_beat(lkp_pkg::FUNC_LOAD, 16'h8000);
    send_beat(lkp_pkg::FUNC_LOAD, 16'h0001);
    send_beat(lkp_pkg::FUNC_LOAD, 16'hAAAA);
    send_beat(lkp_pkg::FUNC_LOAD, 16'h5555);
    send_beat(lkp_pkg::FUNC_LOAD, 16'hFFFF);
    send_beat(lkp_pkg::FUNC_LOAD, 16'h7FFE);
    send_beat(lkp_pkg::FUNC_LOAD, 16'h1234);   // ninth value is dropped
  endtask

  task automatic test_length_bounds();
    set_length(LEN_W'(MAX_LEN));
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);
    set_length(LEN_W'(MAX_LEN));      // rewrite restarts from the first permutation
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);
    set_length('0);
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);
    set_length('1);
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);
  endtask

  task automatic test_restart_and_ignore();
    set_length(LEN_W'(3));
    send_beat(lkp_pkg::FUNC_CLEAR, 16'hFFFF);
    send_beat(lkp_pkg::FUNC_LOAD, 16'd7);
    send_beat(lkp_pkg::FUNC_LOAD, 16'd7);
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);   // length above count
    send_beat(lkp_pkg::FUNC_LOAD, 16'd2);
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);
    send_beat(FUNC_NONE, 16'hFFFF);
    send_beat(lkp_pkg::FUNC_NEXT, 16'h0000);
  endtask

  task automatic test_random_walks();
    int sent;
    int len;
    int base;
    int n;
    int stored;
    int perms;
    int nexts;
    int r;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) len = 0;
      else if (r == 1) len = $urandom_range(MAX_LEN + 1, 15);
      else if (r < 4) len = MAX_LEN;
      else if (r < 7) len = 1;
      else len = $urandom_range(2, 4);
      set_length(LEN_W'(len));
      send_beat(lkp_pkg::FUNC_CLEAR, pick_value());
      sent++;

      base = (len < 1) ? 1 : (len > MAX_LEN) ? MAX_LEN : len;
      r = $urandom_range(0, 9);
      if (r == 0) n = $urandom_range(DEPTH + 1, DEPTH + 2);      // overfill
      else if (r == 1) n = $urandom_range(0, 3);
      else n = (base + $urandom_range(0, 2) > DEPTH) ? DEPTH : base + $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        send_beat(lkp_pkg::FUNC_LOAD, pick_value());
        sent++;
      end

      stored = (n > DEPTH) ? DEPTH : n;
      perms = 0;
      if (len >= 1 && len <= MAX_LEN && len <= stored) begin
        perms = 1;
        for (int i = 0; i < len; i++) perms *= stored - i;
      end
      // short walks run past their end, long ones only sample the opening
      nexts = (perms <= 24) ? perms + $urandom_range(1, 2) : $urandom_range(4, 14);
      for (int i = 0; i < nexts; i++) begin
        r = $urandom_range(0, 29);
        if (r == 0) begin
          send_beat(FUNC_NONE, pick_value());
        end else if (r == 1) begin
          send_beat(lkp_pkg::FUNC_LOAD, pick_value());
          sent++;
        end else if (r == 2) begin
          send_beat(lkp_pkg::FUNC_CLEAR, pick_value());
          sent++;
        end
        send_beat(lkp_pkg::FUNC_NEXT, pick_value());
        sent++;
      end
    end
  endtask

  task automatic report_field(input string fname, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s expected %0h actual %0h", $time, fname, want, got);
  endtask

  always @(posedge clk) begin : check_results
    lkp_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (perm_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: result beat expected none actual %0h", $time, out_beat);
      end else begin
        want = perm_q.pop_front();
        if (out_beat.out_value !== want.out_value)
          report_field("out_value", want.out_value, out_beat.out_value);
        if (out_beat.position !== want.position)
          report_field("position", VAL_W'(want.position), VAL_W'(out_beat.position));
        if (out_beat.last !== want.last)
          report_field("last", VAL_W'(want.last), VAL_W'(out_beat.last));
        if (out_beat.status !== want.status)
          report_field("status", VAL_W'(want.status), VAL_W'(out_beat.status));
      end
    end
  end

  // receiver: runs of free flow, sparse stalls, coin-flip stalls and a regular comb
  always @(posedge clk) begin : stall_pattern
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run = $urandom_range(8, 64);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:   out_stall <= 1'($urandom_range(0, 1));
      default:      out_stall <= (stall_run % 7) < 4;
    endcase
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lex_k_permutation_generator_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    store_cnt = 0;
    perm_len = LEN_W'(1);
    restart_walk();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_default_length();
    test_store_full();
    test_length_bounds();
    test_restart_and_ignore();
    test_random_walks();

    settle();
    if (perm_q.size() != 0) begin
      $display("%0t ns: %0d result beats expected but never seen", $time, perm_q.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("lex_k_permutation_generator_unit: match");
    else
      $display("lex_k_permutation_generator_unit: mismatch");
    $finish;
  end

endmodule

### lex_k_permutation_generator_unit.f
rtl/lkp_pkg.sv
rtl/lkp_free_find.sv
rtl/lex_k_permutation_generator_unit.sv
sim/tb_lex_k_permutation_generator_unit.sv
